FILE: rtl/lbs_pkg.sv
// Shared types, constants and the interpolation step for the lightmap sampler.
// No dependencies; every other file in rtl/ imports this package.
package lbs_pkg;

  localparam int TEXEL_W     = 24;
  localparam int LEVEL_W     = 10;
  localparam int FRAC_W      = 4;
  localparam int ACC_W       = 12;
  localparam int CHAN_W      = 8;
  localparam int N_CORNERS   = 4;
  localparam int N_CHAN      = 3;
  // (255 * 1023) >> 8 fits in ten bits
  localparam int ADD_W       = CHAN_W + LEVEL_W - 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // One input beat: a single style layer
  typedef struct packed {
    logic [TEXEL_W-1:0] texel_00;
    logic [TEXEL_W-1:0] texel_01;
    logic [TEXEL_W-1:0] texel_10;
    logic [TEXEL_W-1:0] texel_11;
    logic [LEVEL_W-1:0] style_level;
    logic [FRAC_W-1:0]  s_fraction;
    logic [FRAC_W-1:0]  t_fraction;
    logic               last_layer;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic [ACC_W-1:0] red;
    logic [ACC_W-1:0] green;
    logic [ACC_W-1:0] blue;
  } out_item_t;

  // Corner sums of one finished sample, indexed [corner][channel]
  typedef logic [N_CORNERS-1:0][N_CHAN-1:0][ACC_W-1:0] sums_t;

  // Work handed from the accumulator to the interpolator
  typedef struct packed {
    sums_t             sums;
    logic [FRAC_W-1:0] s_fraction;
    logic [FRAC_W-1:0] t_fraction;
  } job_t;

  // Queue status seen by its two neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // a + floor((b - a) * f / 16); the result always lies between a and b
  function automatic logic [ACC_W-1:0] lerp4(input logic [ACC_W-1:0]  a,
                                             input logic [ACC_W-1:0]  b,
                                             input logic [FRAC_W-1:0] f);
    logic signed [ACC_W:0]          diff;
    logic signed [ACC_W+FRAC_W+1:0] prod;
    logic signed [ACC_W+FRAC_W+1:0] res;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = $signed({{(FRAC_W+1){diff[ACC_W]}}, diff}) * $signed({{(ACC_W+2){1'b0}}, f});
    res  = $signed({{(FRAC_W+2){1'b0}}, a}) + (prod >>> FRAC_W);
    return res[ACC_W-1:0];
  endfunction

endpackage

FILE: rtl/lbs_accum.sv
// Front end of the sampler: scales each layer's texels and sums them per corner.
// Depends on lbs_pkg; pushes finished corner sums into lbs_queue.
module lbs_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  lbs_pkg::in_item_t in_data,
  input  lbs_pkg::q_stat_t  q_stat,
  output logic              q_push,
  output lbs_pkg::job_t     q_data
);
  import lbs_pkg::*;

  logic [N_CORNERS-1:0][N_CHAN-1:0][ADD_W-1:0] add_r, add_nxt;
  logic [FRAC_W-1:0] sf_r, tf_r;
  logic              last_r;
  logic              p_vld_r, p_vld_nxt;
  sums_t             acc_r, acc_nxt, sat_sum;
  logic              stall, accept, fire;
  logic [N_CORNERS-1:0][TEXEL_W-1:0] texels;

  assign texels = {in_data.texel_11, in_data.texel_10, in_data.texel_01, in_data.texel_00};

  // Stall only when a last layer cannot hand its sums to a full queue
  assign stall   = p_vld_r && last_r && q_stat.full;
  assign in_full = stall;
  assign accept  = in_push && !in_full;
  assign fire    = p_vld_r && !stall;

  // Scale each texel byte by the style level
  always_comb begin
    for (int c = 0; c < N_CORNERS; c++) begin
      for (int k = 0; k < N_CHAN; k++) begin
        logic [CHAN_W+LEVEL_W-1:0] prod;
        prod = {{LEVEL_W{1'b0}}, texels[c][k*CHAN_W +: CHAN_W]} *
               {{CHAN_W{1'b0}}, in_data.style_level};
        add_nxt[c][k] = prod[CHAN_W+LEVEL_W-1:8];
      end
    end
  end

  // Add into the corner sums, saturating at full scale
  always_comb begin
    for (int c = 0; c < N_CORNERS; c++) begin
      for (int k = 0; k < N_CHAN; k++) begin
        logic [ACC_W:0] s;
        s = {1'b0, acc_r[c][k]} + {{(ACC_W+1-ADD_W){1'b0}}, add_r[c][k]};
        sat_sum[c][k] = s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
      end
    end
  end

  // Add each layer into the corner sums; clear them once a sample is handed on
  always_comb begin
    acc_nxt = acc_r;
    if (fire) begin
      acc_nxt = last_r ? '0 : sat_sum;
    end
  end

  assign p_vld_nxt = accept || stall;

  assign q_push            = fire && last_r;
  assign q_data.sums       = sat_sum;
  assign q_data.s_fraction = sf_r;
  assign q_data.t_fraction = tf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      p_vld_r <= p_vld_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Hold the scaled layer until the sum stage takes it
  always_ff @(posedge clk) begin
    if (accept) begin
      add_r  <= add_nxt;
      sf_r   <= in_data.s_fraction;
      tf_r   <= in_data.t_fraction;
      last_r <= in_data.last_layer;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> acc_r == '0)
    else $error("corner sums not cleared after a last layer");

  a_stall_needs_layer: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> p_vld_r)
    else $error("input stalled with no layer waiting");

endmodule

FILE: rtl/lbs_queue.sv
// Short queue of finished corner sums between the accumulator and interpolator.
// Depends on lbs_pkg for the job and status types.
module lbs_queue #(
  parameter int DEPTH = lbs_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lbs_pkg::job_t    wr_data,
  input  logic             pop,
  output lbs_pkg::job_t    rd_data,
  output lbs_pkg::q_stat_t stat
);
  import lbs_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (cnt_r == FULL_CNT);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem[rd_ptr_r];

  // Advance pointers with wrap at the queue depth and track the fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("job popped from an empty queue");

endmodule

FILE: rtl/lbs_interp.sv
// Back end of the sampler: bilinear interpolation of queued corner sums.
// Depends on lbs_pkg (lerp4, job and result types); drives the result port.
module lbs_interp (
  input  logic               clk,
  input  logic               rst_n,
  input  lbs_pkg::job_t      q_data,
  input  lbs_pkg::q_stat_t   q_stat,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output lbs_pkg::out_item_t out_data
);
  import lbs_pkg::*;

  logic [N_CHAN-1:0][ACC_W-1:0] top_r, top_nxt, bot_r, bot_nxt;
  logic [FRAC_W-1:0]            tf_r;
  logic                         s1_vld_r, s1_vld_nxt;
  logic                         o_vld_r, o_vld_nxt;
  logic [N_CHAN-1:0][ACC_W-1:0] res_nxt;
  out_item_t                    o_data_r;
  logic                         s1_adv, o_adv;

  // Move forward whenever the next stage has room
  assign o_adv  = !o_vld_r || out_pop;
  assign s1_adv = !s1_vld_r || o_adv;
  assign q_pop  = s1_adv && !q_stat.empty;

  // Interpolate along s on both rows
  always_comb begin
    for (int k = 0; k < N_CHAN; k++) begin
      top_nxt[k] = lerp4(q_data.sums[0][k], q_data.sums[1][k], q_data.s_fraction);
      bot_nxt[k] = lerp4(q_data.sums[2][k], q_data.sums[3][k], q_data.s_fraction);
    end
  end

  // Interpolate along t between the rows
  always_comb begin
    for (int k = 0; k < N_CHAN; k++) begin
      res_nxt[k] = lerp4(top_r[k], bot_r[k], tf_r);
    end
  end

  assign s1_vld_nxt = s1_adv ? !q_stat.empty : s1_vld_r;
  assign o_vld_nxt  = o_adv ? s1_vld_r : o_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      tf_r  <= q_data.t_fraction;
    end
    if (o_adv && s1_vld_r) begin
      o_data_r.red   <= res_nxt[0];
      o_data_r.green <= res_nxt[1];
      o_data_r.blue  <= res_nxt[2];
    end
  end

  assign out_empty = !o_vld_r;
  assign out_data  = o_data_r;

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && o_adv) |=> o_vld_r)
    else $error("row result dropped before the output register");

endmodule

FILE: rtl/lightmap_bilinear_sampler.sv
// Top level of the lightmap bilinear sampler: accumulator, job queue, interpolator.
// Depends on lbs_pkg, lbs_accum, lbs_queue and lbs_interp.
//
//   channel  ports                       beat
//   input    in_push, in_full, in_data    one style layer (in_item_t)
//   result   out_pop, out_empty, out_data one RGB sample (out_item_t)
//
// One layer is accepted per cycle while in_full is low. A layer waits in the
// scale register, whose output the corner-sum adders fold into the sums; a last
// layer then goes through the job queue and two interpolation registers before
// its result appears. Reset is synchronous and empties all stages and clears the
// corner sums. A stalled result fills the queue (QUEUE_DEPTH jobs), after which
// in_full rises on the next last layer.
module lightmap_bilinear_sampler #(
  parameter int QUEUE_DEPTH = lbs_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  lbs_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output lbs_pkg::out_item_t out_data
);
  import lbs_pkg::*;

  q_stat_t q_stat;
  logic    q_push, q_pop;
  job_t    q_wr, q_rd;

  lbs_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_wr)
  );

  lbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  lbs_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_rd),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
